// ----- rtl/vie_pkg.sv -----
// shared types, opcodes and the 8-bit float decode and encode functions for the vole execute core
package vie_pkg;

  localparam int RegCount = 16;
  localparam int MemBytes = 256;
  localparam int RegIdxW = $clog2(RegCount);
  localparam int AddrW = $clog2(MemBytes);

  localparam logic [3:0] OP_LOAD_MEM = 4'h1;
  localparam logic [3:0] OP_LOAD_IMM = 4'h2;
  localparam logic [3:0] OP_STORE = 4'h3;
  localparam logic [3:0] OP_COPY = 4'h4;
  localparam logic [3:0] OP_ADD_INT = 4'h5;
  localparam logic [3:0] OP_ADD_FLT = 4'h6;
  localparam logic [3:0] OP_OR = 4'h7;
  localparam logic [3:0] OP_AND = 4'h8;
  localparam logic [3:0] OP_XOR = 4'h9;
  localparam logic [3:0] OP_ROT = 4'hA;
  localparam logic [3:0] OP_JEQ = 4'hB;
  localparam logic [3:0] OP_HALT = 4'hC;
  localparam logic [3:0] OP_JGT = 4'hD;

  typedef struct packed {
    logic kind;
    logic [15:0] word;
    logic [AddrW-1:0] load_address;
    logic [7:0] load_value;
  } item_t;

  typedef struct packed {
    logic [AddrW-1:0] next_pc;
    logic halted;
    logic reg_written;
    logic [RegIdxW-1:0] reg_index;
    logic [7:0] reg_value;
    logic mem_written;
    logic [AddrW-1:0] mem_address;
    logic [7:0] mem_value;
  } result_t;

  function automatic logic signed [12:0] fl_decode(input logic [7:0] b);
    logic [11:0] mag;
    mag = {8'd0, b[3:0]} << b[6:4];
    fl_decode = b[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  function automatic logic [7:0] fl_encode(input logic signed [12:0] v);
    logic [12:0] a;
    logic [7:0] res;
    logic done;
    a = v[12] ? 13'(-v) : v;
    res = {v[12], 7'h7F};
    done = 1'b0;
    if (a == 13'd0) begin
      res = 8'h00;
      done = 1'b1;
    end
    for (int e = 0; e < 8; e++) begin
      if (!done && (a >> e) <= 13'd15) begin
        res = {v[12], 3'(e), 4'(a >> e)};
        done = 1'b1;
      end
    end
    fl_encode = res;
  endfunction

endpackage

// ----- rtl/vie_ram.sv -----
// generic ram with one write port and one read port, registered reads
module vie_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= (we && waddr == raddr) ? wdata : mem[raddr];
  end
endmodule

// ----- rtl/vie_front.sv -----
// input side: accepts items and holds them in a two-entry queue
module vie_front (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  vie_pkg::item_t in_item,
  output logic q_valid,
  output vie_pkg::item_t q_item,
  input  logic q_take
);
  import vie_pkg::*;
  item_t slots [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;
  logic do_push, do_pop;

  assign full = (count == 2'd2);
  assign do_push = push && !full;
  assign do_pop = q_take && q_valid;
  assign q_valid = (count != 2'd0);
  assign q_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= in_item;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst) (do_push && !do_pop) |=> q_valid)
    else $error("pushed item lost");
endmodule

// ----- rtl/vie_back.sv -----
// execution side: register file, data memory, pc and result register
module vie_back (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  vie_pkg::item_t q_item,
  output logic q_take,
  output logic out_valid,
  output vie_pkg::result_t out_res,
  input  logic out_pop
);
  import vie_pkg::*;

  // memory clearing pass after reset
  logic clearing;
  logic [AddrW:0] clr_cnt;

  logic [7:0] regs [RegCount];
  logic [AddrW-1:0] pc;
  logic stop;

  // stage 1 holds the item while the memory read completes
  logic s1_valid;
  item_t s1;
  logic [7:0] mem_rd;

  logic [3:0] op;
  logic [RegIdxW-1:0] r, s, t;
  logic [AddrW-1:0] xy;
  result_t res;
  logic [8:0] next;
  logic stop_next;
  logic [7:0] rv_r, rv_s, rv_t, rv_0;
  logic [2:0] k;
  logic [15:0] rot2;
  logic adv;

  logic mem_we;
  logic [AddrW-1:0] mem_wa;
  logic [7:0] mem_wd;

  // stage 1 advances when result slot is free or being taken
  assign adv = !out_valid || out_pop;
  assign q_take = !clearing && (!s1_valid || adv);

  assign op = s1.word[15:12];
  assign r = s1.word[11:8];
  assign s = s1.word[7:4];
  assign t = s1.word[3:0];
  assign xy = s1.word[7:0];
  assign rv_r = regs[r];
  assign rv_s = regs[s];
  assign rv_t = regs[t];
  assign rv_0 = regs[0];
  assign k = t[2:0];
  assign rot2 = {rv_r, rv_r} >> k;

  always_comb begin
    res = '0;
    next = {1'b0, pc} + 9'd2;
    stop_next = stop;
    if (s1.kind) begin
      res.mem_written = 1'b1;
      res.mem_address = s1.load_address;
      res.mem_value = s1.load_value;
      next = {1'b0, pc};
    end else if (stop) begin
      next = {1'b0, pc};
    end else begin
      case (op)
        OP_LOAD_MEM: begin res.reg_written = 1'b1; res.reg_index = r; res.reg_value = mem_rd; end
        OP_LOAD_IMM: begin res.reg_written = 1'b1; res.reg_index = r; res.reg_value = xy; end
        OP_STORE: begin res.mem_written = 1'b1; res.mem_address = xy; res.mem_value = rv_r; end
        OP_COPY: begin res.reg_written = 1'b1; res.reg_index = t; res.reg_value = rv_s; end
        OP_ADD_INT: begin res.reg_written = 1'b1; res.reg_index = r; res.reg_value = rv_s + rv_t; end
        OP_ADD_FLT: begin
          res.reg_written = 1'b1; res.reg_index = r;
          res.reg_value = fl_encode(fl_decode(rv_s) + fl_decode(rv_t));
        end
        OP_OR: begin res.reg_written = 1'b1; res.reg_index = r; res.reg_value = rv_s | rv_t; end
        OP_AND: begin res.reg_written = 1'b1; res.reg_index = r; res.reg_value = rv_s & rv_t; end
        OP_XOR: begin res.reg_written = 1'b1; res.reg_index = r; res.reg_value = rv_s ^ rv_t; end
        OP_ROT: begin res.reg_written = 1'b1; res.reg_index = r; res.reg_value = rot2[7:0]; end
        OP_JEQ: if (rv_r == rv_0) next = {1'b0, xy};
        OP_HALT: begin stop_next = 1'b1; next = {1'b0, pc}; end
        OP_JGT: if ($signed(rv_r) > $signed(rv_0)) next = {1'b0, xy};
        default: ;
      endcase
      if (next[8]) stop_next = 1'b1;
    end
    res.next_pc = next[7:0];
    res.halted = stop_next;
  end

  // a write from the retiring item to the address being read is forwarded in the ram
  assign mem_we = clearing || (s1_valid && adv && res.mem_written);
  assign mem_wa = clearing ? clr_cnt[AddrW-1:0] : res.mem_address;
  assign mem_wd = clearing ? 8'd0 : res.mem_value;

  vie_ram #(.Width(8), .Depth(MemBytes)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_wa), .wdata(mem_wd),
    .re(q_take), .raddr(q_item.word[7:0]), .rdata(mem_rd)
  );

  always_ff @(posedge clk) begin
    if (q_take && q_valid) s1 <= q_item;
    if (s1_valid && adv) out_res <= res;
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt <= '0;
      pc <= '0;
      stop <= 1'b0;
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < RegCount; i++) regs[i] <= 8'd0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt[AddrW-1:0] == AddrW'(MemBytes - 1)) clearing <= 1'b0;
      end
      if (q_take) s1_valid <= q_valid;
      else if (adv) s1_valid <= 1'b0;
      if (s1_valid && adv) begin
        pc <= res.next_pc;
        stop <= res.halted;
        out_valid <= 1'b1;
        if (res.reg_written) regs[res.reg_index] <= res.reg_value;
      end else if (out_pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) clearing |-> !q_take)
    else $error("item taken during memory clear");
  assert property (@(posedge clk) disable iff (rst) (out_valid && !out_pop) |=> out_valid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst) $past(stop) |-> stop)
    else $error("halt flag cleared");
endmodule

// ----- rtl/vole_instruction_execute_core.sv -----
// top level of the vole instruction execute core
// an item passes the input queue, stage 1 and the result register before it shows as a result
// throughput: one item per cycle while results are popped and no clearing pass runs; the data memory read is registered
// reset: synchronous; then a memory clearing pass that zeroes all 256 bytes, up to two items queue meanwhile
// registers, pc and halt flag clear at once
module vole_instruction_execute_core (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic kind,
  input  logic [15:0] instruction_word,
  input  logic [vie_pkg::AddrW-1:0] load_address,
  input  logic [7:0] load_value,
  output logic empty,
  input  logic pop,
  output logic [vie_pkg::AddrW-1:0] next_pc,
  output logic halted,
  output logic reg_written,
  output logic [vie_pkg::RegIdxW-1:0] reg_index,
  output logic [7:0] reg_value,
  output logic mem_written,
  output logic [vie_pkg::AddrW-1:0] mem_address,
  output logic [7:0] mem_value
);
  import vie_pkg::*;
  item_t in_item, q_item;
  result_t res;
  logic q_valid, q_take, out_valid;

  assign in_item = '{kind: kind, word: instruction_word,
                     load_address: load_address, load_value: load_value};

  vie_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .q_valid(q_valid), .q_item(q_item), .q_take(q_take)
  );

  vie_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item), .q_take(q_take),
    .out_valid(out_valid), .out_res(res), .out_pop(pop)
  );

  assign empty = !out_valid;
  assign next_pc = res.next_pc;
  assign halted = res.halted;
  assign reg_written = res.reg_written;
  assign reg_index = res.reg_index;
  assign reg_value = res.reg_value;
  assign mem_written = res.mem_written;
  assign mem_address = res.mem_address;
  assign mem_value = res.mem_value;
endmodule
